[hdl/qnl_pkg.sv]
// Shared types and constants for the quaternion nlerp pipeline.
`timescale 1ns / 1ps

package qnl_pkg;

    localparam int COMP_FRAC_BITS  = 14;
    localparam int BLEND_FRAC_BITS = 16;
    localparam int ROOT_BITS       = 15;

    localparam logic [16:0] BLEND_ONE = 17'h10000;
    localparam logic [32:0] LEN_UNIT  = 33'h010000000;

    // Register byte addresses
    localparam logic [2:0] ADDR_SHORTEST_PATH = 3'd0;

    // Result status codes
    typedef enum logic [1:0] {
        ST_RESCALED = 2'd0,
        ST_UNIT     = 2'd1,
        ST_ZERO     = 2'd2
    } status_t;

    // Per-component working set of the root search
    typedef struct packed {
        logic signed [17:0] c;
        logic [30:0]        sq;
        logic [14:0]        n;
        logic signed [67:0] p;
        logic signed [49:0] q;
    } lane_t;

    // One item as it moves through the root stages
    typedef struct packed {
        logic            vld;
        status_t         status;
        logic [32:0]     len;
        lane_t [3:0]     lane;
    } item_t;

endpackage

[hdl/qnl_front.sv]
// Front end: dot product, shortest-path flip, blend, rounding and squared length.
`timescale 1ns / 1ps

module qnl_front
    import qnl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             shortest_path,
    input  logic             in_vld,
    input  logic [3:0][15:0] a_in,
    input  logic [3:0][15:0] b_in,
    input  logic [16:0]      t_in,
    output item_t            item
);

    logic               va_reg, vb_reg, vc_reg, vd_reg, ve_reg, vf_reg;
    logic signed [15:0] a_a_reg [4];
    logic signed [15:0] b_a_reg [4];
    logic [16:0]        t_a_reg;
    logic signed [15:0] a_b_reg [4];
    logic signed [15:0] b_b_reg [4];
    logic signed [31:0] p_b_reg [4];
    logic [16:0]        t_b_reg;
    logic signed [15:0] a_c_reg [4];
    logic signed [16:0] b_c_reg [4];
    logic [16:0]        t_c_reg;
    logic signed [33:0] pa_d_reg [4];
    logic signed [34:0] pb_d_reg [4];
    logic signed [17:0] c_e_reg [4];
    logic signed [17:0] c_f_reg [4];
    logic [30:0]        sq_f_reg [4];
    item_t              item_reg, item_next;

    logic signed [33:0] dot;
    logic               flip;
    logic signed [16:0] b_c_next [4];
    logic signed [33:0] pa_next [4];
    logic signed [34:0] pb_next [4];
    logic signed [17:0] c_next [4];
    logic [30:0]        sq_next [4];

    // Dot product and flip of b
    always_comb
    begin
        dot = '0;
        for (int i = 0; i < 4; i++)
        begin
            dot = dot + 34'(p_b_reg[i]);
        end
        flip = shortest_path && dot[33];
        for (int i = 0; i < 4; i++)
        begin
            b_c_next[i] = flip ? -17'(b_b_reg[i]) : 17'(b_b_reg[i]);
        end
    end

    // Blend products, rounding and squares
    always_comb
    begin
        logic signed [35:0] acc;
        logic signed [35:0] sqw;
        for (int i = 0; i < 4; i++)
        begin
            pa_next[i] = 34'(a_c_reg[i]) * 34'($signed({1'b0, BLEND_ONE - t_c_reg}));
            pb_next[i] = 35'(b_c_reg[i]) * 35'($signed({1'b0, t_c_reg}));
            acc        = 36'(pa_d_reg[i]) + 36'(pb_d_reg[i]) + 36'sd32768;
            c_next[i]  = 18'(acc >>> BLEND_FRAC_BITS);
            sqw        = 36'(c_e_reg[i]) * 36'(c_e_reg[i]);
            sq_next[i] = sqw[30:0];
        end
    end

    // Squared length, status and start of the root search
    always_comb
    begin
        logic [32:0] len;
        len = '0;
        for (int i = 0; i < 4; i++)
        begin
            len = len + 33'(sq_f_reg[i]);
        end
        item_next.vld = vf_reg;
        item_next.len = len;
        if (len == '0)
        begin
            item_next.status = ST_ZERO;
        end
        else if (len == LEN_UNIT)
        begin
            item_next.status = ST_UNIT;
        end
        else
        begin
            item_next.status = ST_RESCALED;
        end
        for (int i = 0; i < 4; i++)
        begin
            item_next.lane[i].c  = c_f_reg[i];
            item_next.lane[i].sq = sq_f_reg[i];
            item_next.lane[i].n  = '0;
            item_next.lane[i].p  = 68'($signed({1'b0, len}));
            item_next.lane[i].q  = -50'($signed({1'b0, len}));
        end
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vc_reg   <= 1'b0;
            vd_reg   <= 1'b0;
            ve_reg   <= 1'b0;
            vf_reg   <= 1'b0;
            item_reg <= '0;
        end
        else if (en)
        begin
            va_reg   <= in_vld;
            vb_reg   <= va_reg;
            vc_reg   <= vb_reg;
            vd_reg   <= vc_reg;
            ve_reg   <= vd_reg;
            vf_reg   <= ve_reg;
            item_reg <= item_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_a_reg <= (t_in > BLEND_ONE) ? BLEND_ONE : t_in;
            t_b_reg <= t_a_reg;
            t_c_reg <= t_b_reg;
            for (int i = 0; i < 4; i++)
            begin
                a_a_reg[i]  <= $signed(a_in[i]);
                b_a_reg[i]  <= $signed(b_in[i]);
                a_b_reg[i]  <= a_a_reg[i];
                b_b_reg[i]  <= b_a_reg[i];
                p_b_reg[i]  <= 32'(a_a_reg[i]) * 32'(b_a_reg[i]);
                a_c_reg[i]  <= a_b_reg[i];
                b_c_reg[i]  <= b_c_next[i];
                pa_d_reg[i] <= pa_next[i];
                pb_d_reg[i] <= pb_next[i];
                c_e_reg[i]  <= c_next[i];
                c_f_reg[i]  <= c_e_reg[i];
                sq_f_reg[i] <= sq_next[i];
            end
        end
    end

    assign item = item_reg;

endmodule

[hdl/qnl_root_stage.sv]
// One bit of the rounded c * 2^14 / sqrt(len) search, all four components.
`timescale 1ns / 1ps

module qnl_root_stage
    import qnl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [3:0]  bit_idx,
    input  item_t       in_item,
    output item_t       out_item
);

    item_t item_reg, item_next;

    // Trial n | 2^k: keep P = (2n-1)^2 * len and Q = (2n-1) * len up to date
    always_comb
    begin
        logic signed [67:0] lenw;
        logic signed [67:0] pt;
        logic signed [49:0] qt;
        logic signed [67:0] lim;
        item_next = in_item;
        lenw      = 68'($signed({1'b0, in_item.len}));
        for (int i = 0; i < 4; i++)
        begin
            pt  = in_item.lane[i].p + (68'(in_item.lane[i].q) <<< (6'(bit_idx) + 6'd2))
                  + (lenw <<< ({2'b0, bit_idx, 1'b0} + 7'd2));
            qt  = in_item.lane[i].q + (50'(lenw) <<< (6'(bit_idx) + 6'd1));
            lim = 68'($signed({1'b0, in_item.lane[i].sq, 30'b0}));
            if (pt <= lim)
            begin
                item_next.lane[i].n = in_item.lane[i].n | (15'd1 << bit_idx);
                item_next.lane[i].p = pt;
                item_next.lane[i].q = qt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_item = item_reg;

endmodule

[hdl/quaternion_nlerp_core.sv]
// Top level of the quaternion nlerp pipeline with its configuration port.
//
//   port group  | direction | contents
//   s_*         | in        | a, b quaternions and blend factor, one item per transfer
//   m_*         | out       | normalised quaternion, status in tuser
//   APB         | in/out    | shortest_path register at address 0
//
// The pipeline has seven front stages, fifteen root stages (one result
// bit each) and the output register. One item is taken per cycle unless a stall holds the pipeline.
// All stages advance together whenever the output register is empty or taken;
// a stall holds every stage. rst_n clears valid bits and sets shortest_path.
`timescale 1ns / 1ps

module quaternion_nlerp_core
    import qnl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [151:0] s_tdata,   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, blend, zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // q_w, q_x, q_y, q_z
    output logic [1:0]   m_tuser,   // status
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic             shortest_path_reg;
    logic             en;
    logic [3:0][15:0] a_in, b_in;
    item_t            chain [ROOT_BITS + 1];
    logic             m_tvalid_reg;
    logic [63:0]      m_tdata_reg, m_tdata_next;
    logic [1:0]       m_tuser_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shortest_path_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && paddr == ADDR_SHORTEST_PATH)
        begin
            shortest_path_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SHORTEST_PATH) ? {31'b0, shortest_path_reg} : 32'b0;

    // Global advance
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            a_in[i] = s_tdata[16*i +: 16];
            b_in[i] = s_tdata[64 + 16*i +: 16];
        end
    end

    qnl_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .shortest_path (shortest_path_reg),
        .in_vld        (s_tvalid),
        .a_in          (a_in),
        .b_in          (b_in),
        .t_in          (s_tdata[144:128]),
        .item          (chain[0])
    );

    // Root search, most significant bit first
    for (genvar g = 0; g < ROOT_BITS; g++)
    begin : g_root
        qnl_root_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .bit_idx  (4'(ROOT_BITS - 1 - g)),
            .in_item  (chain[g]),
            .out_item (chain[g + 1])
        );
    end

    // Result selection
    always_comb
    begin
        logic signed [17:0] c;
        logic [15:0]        v;
        for (int i = 0; i < 4; i++)
        begin
            c = chain[ROOT_BITS].lane[i].c;
            unique case (chain[ROOT_BITS].status)
                ST_ZERO:
                begin
                    v = '0;
                end
                ST_UNIT:
                begin
                    v = (c > 18'sd32767) ? 16'h7FFF :
                        (c < -18'sd32768) ? 16'h8000 : c[15:0];
                end
                ST_RESCALED:
                begin
                    v = c[17] ? -{1'b0, chain[ROOT_BITS].lane[i].n}
                              : {1'b0, chain[ROOT_BITS].lane[i].n};
                end
                default:
                begin
                    v = '0;
                end
            endcase
            m_tdata_next[16*i +: 16] = v;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= chain[ROOT_BITS].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= chain[ROOT_BITS].status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef ASSERT_OFF
    // Zero-length results carry all-zero components
    a_zero_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_ZERO |-> m_tdata == 64'b0)
        else $error("zero-length item with nonzero components");

    // A rescaled component never exceeds unit magnitude
    a_rescale_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_RESCALED |->
            $signed(m_tdata[15:0]) <= 16'sd16384 && $signed(m_tdata[15:0]) >= -16'sd16384)
        else $error("rescaled component out of range");

    // Register write lands on the next edge
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr == ADDR_SHORTEST_PATH
            |=> shortest_path_reg == $past(pwdata[0]))
        else $error("shortest_path write lost");
`endif

endmodule
